>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of i_clk, off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication checked at every rising edge of i_clk, off while reset is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

>>> src/lruol_pkg.sv
// Package of the LRU order list: sizes, command and status codes, transfer types.
// No dependencies; used by every module of the block.
package lruol_pkg;

    localparam int DEPTH    = 16;
    localparam int TAG_BITS = 16;
    localparam int IDX_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_MOVE   = 2'd2;
    localparam logic [1:0] CMD_EVICT  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [TAG_BITS-1:0] tag;
    } t_in_item;

    typedef struct packed {
        logic [TAG_BITS-1:0] lru_tag;
        logic                nonempty;
        logic [CNT_BITS-1:0] entry_count;
        logic [1:0]          status;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic append;
        logic remove;
        logic move;
        logic evict;
    } t_dp_ops;

    // datapath -> controller
    typedef struct packed {
        logic found;
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

>>> src/lruol_dp.sv
// Datapath of the LRU order list: tag store, parallel match, shift and write.
// Depends on lruol_pkg.
module lruol_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lruol_pkg::t_dp_ops           i_ops,
    input  logic [lruol_pkg::TAG_BITS-1:0] i_tag,
    output lruol_pkg::t_dp_stat          o_stat,
    output logic [lruol_pkg::TAG_BITS-1:0] o_lru_tag,
    output logic [lruol_pkg::CNT_BITS-1:0] o_count
);

    logic [lruol_pkg::TAG_BITS-1:0] r_store [lruol_pkg::DEPTH];
    logic [lruol_pkg::TAG_BITS-1:0] n_store [lruol_pkg::DEPTH];
    logic [lruol_pkg::TAG_BITS-1:0] r_tag;
    logic [lruol_pkg::CNT_BITS-1:0] r_count;
    logic [lruol_pkg::CNT_BITS-1:0] n_count;

    logic [lruol_pkg::DEPTH-1:0]    match;
    logic [lruol_pkg::DEPTH-1:0]    at_or_after;   // positions from the oldest hit upward
    logic [lruol_pkg::DEPTH-1:0]    shift_en;
    logic [lruol_pkg::IDX_BITS-1:0] wr_pos;
    logic                           wr_en;
    logic                           found;
    logic                           full;
    logic                           empty;

    assign full  = (r_count == lruol_pkg::CNT_BITS'(lruol_pkg::DEPTH));
    assign empty = (r_count == '0);
    assign found = |match;

    always_comb begin
        for (int i = 0; i < lruol_pkg::DEPTH; i++) begin
            match[i] = (r_store[i] == r_tag) && (lruol_pkg::CNT_BITS'(i) < r_count);
        end
        at_or_after[0] = match[0];
        for (int i = 1; i < lruol_pkg::DEPTH; i++) begin
            at_or_after[i] = at_or_after[i-1] | match[i];
        end
    end

    always_comb begin
        shift_en = '0;
        wr_en    = 1'b0;
        wr_pos   = r_count[lruol_pkg::IDX_BITS-1:0];
        n_count  = r_count;
        if (i_ops.append && !full) begin
            wr_en   = 1'b1;
            n_count = r_count + 1'b1;
        end
        if (i_ops.remove && found) begin
            shift_en = at_or_after;
            n_count  = r_count - 1'b1;
        end
        if (i_ops.move && found) begin
            // close the gap, then the tag lands on the last occupied slot
            shift_en = at_or_after;
            wr_en    = 1'b1;
            wr_pos   = lruol_pkg::IDX_BITS'(r_count - 1'b1);
        end
        if (i_ops.evict && !empty) begin
            shift_en = '1;
            n_count  = r_count - 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < lruol_pkg::DEPTH; i++) begin
            n_store[i] = r_store[i];
            if (shift_en[i] && (i < lruol_pkg::DEPTH - 1)) begin
                n_store[i] = r_store[(i + 1) % lruol_pkg::DEPTH];
            end
            if (wr_en && (wr_pos == lruol_pkg::IDX_BITS'(i))) begin
                n_store[i] = r_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ops.load) begin
            r_tag <= i_tag;
        end
        r_store <= n_store;
    end

    assign o_stat.found = found;
    assign o_stat.full  = full;
    assign o_stat.empty = empty;
    assign o_lru_tag    = empty ? '0 : r_store[0];
    assign o_count      = r_count;

endmodule

>>> src/lruol_ctrl.sv
// Controller of the LRU order list: accept, execute and result strobe.
// Depends on lruol_pkg.
module lruol_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_cmd,
    input  lruol_pkg::t_dp_stat  i_stat,
    output lruol_pkg::t_dp_ops   o_ops,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [1:0]           o_status
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic       r_state;
    logic       n_state;
    logic [1:0] r_cmd;
    logic       r_done;
    logic       n_done;
    logic [1:0] r_status;
    logic [1:0] n_status;
    logic       accept;

    assign o_busy = (r_state == S_EXEC);
    assign accept = i_start && !o_busy;

    always_comb begin
        o_ops      = '0;
        o_ops.load = accept;
        n_state    = r_state;
        n_done     = 1'b0;
        n_status   = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                n_status = lruol_pkg::ST_OK;
                unique case (r_cmd)
                    lruol_pkg::CMD_APPEND: begin
                        o_ops.append = 1'b1;
                        if (i_stat.full) n_status = lruol_pkg::ST_FULL;
                    end
                    lruol_pkg::CMD_REMOVE: begin
                        o_ops.remove = 1'b1;
                        if (!i_stat.found) n_status = lruol_pkg::ST_NOT_FOUND;
                    end
                    lruol_pkg::CMD_MOVE: begin
                        o_ops.move = 1'b1;
                        if (!i_stat.found) n_status = lruol_pkg::ST_NOT_FOUND;
                    end
                    lruol_pkg::CMD_EVICT: begin
                        o_ops.evict = 1'b1;
                        if (i_stat.empty) n_status = lruol_pkg::ST_EMPTY;
                    end
                    default: begin
                        n_status = lruol_pkg::ST_OK;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_status <= n_status;
    end

    assign o_done   = r_done;
    assign o_status = r_status;

endmodule

>>> src/lru_order_list_top.sv
// Top level of the LRU order list: controller plus tag-store datapath.
// Depends on lruol_pkg, lruol_ctrl and lruol_dp.
//
// The block keeps up to DEPTH (16) tags ordered from least to most recently
// used. A command transfer (append, remove, move to MRU, evict head) is taken
// at a rising edge with start high and busy low. The tag is registered on
// accept, and in the next cycle one parallel compare over all stored entries
// finds the oldest match while the store shifts and writes in the same edge.
// The result (LRU tag, nonempty, count, status) is shown for exactly one
// cycle with o_done high, the cycle after that; the receiver cannot stall it,
// so capture it then. busy is high only during the execute cycle, so a new
// command may be issued in the same cycle as o_done. Absent tags, an append
// to a full list and an evict from an empty list leave the list unchanged
// and are flagged in status. Reset empties the list; tag slots at or above
// the count hold stale data that is never shown.
module lru_order_list_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lruol_pkg::t_in_item  i_item,
    output logic                 o_done,
    output lruol_pkg::t_out_item o_result
);

    lruol_pkg::t_dp_ops  ops;
    lruol_pkg::t_dp_stat stat;
    logic [lruol_pkg::TAG_BITS-1:0] lru_tag;
    logic [lruol_pkg::CNT_BITS-1:0] count;
    logic [1:0]                     status;

    lruol_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_item.cmd),
        .i_stat   (stat),
        .o_ops    (ops),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_status (status)
    );

    lruol_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ops     (ops),
        .i_tag     (i_item.tag),
        .o_stat    (stat),
        .o_lru_tag (lru_tag),
        .o_count   (count)
    );

    // state is stable in the strobe cycle, so the fields read it directly
    assign o_result.lru_tag     = lru_tag;
    assign o_result.nonempty    = (count != '0);
    assign o_result.entry_count = count;
    assign o_result.status      = status;

endmodule

>>> src/lruol_checker.sv
// Port-level checker of the LRU order list, bound to the top level.
// Depends on lruol_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lruol_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input lruol_pkg::t_out_item o_result
);

    localparam logic [lruol_pkg::CNT_BITS-1:0] FULL_CNT =
        lruol_pkg::CNT_BITS'(lruol_pkg::DEPTH);

    logic accept;
    logic full_done;

    assign accept    = start && !busy;
    assign full_done = o_done && (o_result.status == lruol_pkg::ST_FULL);

    `ASSERT_IMPL(a_accept_busy, accept, ##1 (busy && !o_done), "accept must raise busy")
    `ASSERT_IMPL(a_accept_done, accept, ##2 o_done, "no result two cycles after accept")
    `ASSERT_CLK(a_done_once, o_done |=> !o_done, "result strobe longer than one cycle")
    `ASSERT_IMPL(a_count_max, o_done, o_result.entry_count <= FULL_CNT, "count over depth")
    `ASSERT_IMPL(a_full_count, full_done, o_result.entry_count == FULL_CNT, "full with room left")

endmodule

bind lru_order_list_top lruol_checker u_lruol_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
